// ----- rtl/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CHK_IMPLIES(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CHK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication that stays active through reset.
`define CHK_NEXT_ALWAYS(label, clk, ante, cons) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ----- rtl/mclsc_pkg.sv -----
// Package with types, constants and helpers of the majority-clocked LFSR stream cipher.
`default_nettype none

package mclsc_pkg;

    localparam int unsigned KEY_W   = 64;
    localparam int unsigned BYTE_W  = 8;
    localparam int unsigned LEN_A   = 19;
    localparam int unsigned LEN_B   = 22;
    localparam int unsigned LEN_C   = 23;

    localparam logic [KEY_W-1:0] KEY_RESET = 64'hD51A_CCCE_A5C2_D982;

    typedef struct packed {
        logic [LEN_A-1:0] a;
        logic [LEN_B-1:0] b;
        logic [LEN_C-1:0] c;
    } lfsr_state_t;

    // Register A takes the top 19 key bits, B the next 22 and C the low 23.
    function automatic lfsr_state_t load_from_key(input logic [KEY_W-1:0] k);
        lfsr_state_t s;
        s.a = k[63:45];
        s.b = k[44:23];
        s.c = k[22:0];
        return s;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/majority_clocked_lfsr_stream_cipher_top.sv -----
// Top level of the majority-clocked LFSR stream cipher with stream channels and key port.
`default_nettype none

// Usage
// The block encrypts or decrypts one byte per transaction; both directions are the
// same operation. Input transactions arrive on the s_ channel: s_tdata carries the
// byte and s_tuser[0] flags the first byte of a message, which reloads the three
// shift registers from the key before that byte is processed. Results leave on the
// m_ channel, one output transaction for every input transaction, in order.
// The key is written through the cfg_ channel (cfg_ready is always high); a new
// key takes effect at the next byte that carries the first-byte flag. Write it
// only while no bytes are in flight.
// An input transaction is captured in the input register and its result in the
// output register, from which it is offered. A new byte can be accepted every
// cycle while the receiver takes results: the eight register steps of one byte are
// done in one pass of logic between the input register and the output register.
// When the receiver stalls, the output register holds its result and the input
// register takes one more byte before s_tready falls.
// Reset empties both pipeline registers, restores the default key and loads the
// shift registers from it, so a stream without a first-byte flag continues from
// the default key.

module majority_clocked_lfsr_stream_cipher_top
    import mclsc_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    // Input channel.
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] data_byte
    input  logic [0:0]        s_tuser,   // [0] first_byte
    // Result channel.
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] out_byte
    // Key write channel.
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [KEY_W-1:0]  cfg_data
);

    logic              in_valid_reg;
    logic              in_valid_next;
    logic [BYTE_W-1:0] in_data_reg;
    logic              in_first_reg;
    logic              out_valid_reg;
    logic              out_valid_next;
    logic [BYTE_W-1:0] out_data_reg;
    logic [KEY_W-1:0]  key_reg;
    logic [KEY_W-1:0]  key_next;
    lfsr_state_t       state_reg;
    lfsr_state_t       state_next;
    lfsr_state_t       ks_state;
    logic [BYTE_W-1:0] ks_data;
    logic              s_fire;
    logic              advance;

    // The byte in the input register moves on when the output register is free
    // or is being emptied in this cycle.
    assign advance   = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || advance;
    assign s_fire    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    mclsc_keystream u_keystream (
        .state_in  (state_reg),
        .key       (key_reg),
        .reload    (in_first_reg),
        .data_in   (in_data_reg),
        .state_out (ks_state),
        .data_out  (ks_data)
    );

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_fire) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end

        key_next = key_reg;
        if (cfg_valid && cfg_ready) begin
            key_next = cfg_data;
        end

        // The shift registers only step when a byte is actually processed.
        state_next = state_reg;
        if (advance) begin
            state_next = ks_state;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            key_reg       <= KEY_RESET;
            state_reg     <= load_from_key(KEY_RESET);
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            key_reg       <= key_next;
            state_reg     <= state_next;
        end
    end

    // Payload registers carry no reset; their valid flags qualify them.
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            in_data_reg  <= s_tdata;
            in_first_reg <= s_tuser[0];
        end
        if (advance) begin
            out_data_reg <= ks_data;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

endmodule

`default_nettype wire

// ----- rtl/mclsc_keystream.sv -----
// Combinational keystream datapath: optional reload, eight majority-clocked steps, XOR.
`default_nettype none

module mclsc_keystream
    import mclsc_pkg::*;
(
    input  lfsr_state_t       state_in,
    input  logic [KEY_W-1:0]  key,
    input  logic              reload,
    input  logic [BYTE_W-1:0] data_in,
    output lfsr_state_t       state_out,
    output logic [BYTE_W-1:0] data_out
);

    always_comb begin
        lfsr_state_t       loaded;
        logic [LEN_A-1:0]  a;
        logic [LEN_B-1:0]  b;
        logic [LEN_C-1:0]  c;
        logic [BYTE_W-1:0] ks;
        logic              ca;
        logic              cb;
        logic              cc;
        logic              maj;
        logic              bit_ks;

        loaded = load_from_key(key);
        if (reload) begin
            a = loaded.a;
            b = loaded.b;
            c = loaded.c;
        end else begin
            a = state_in.a;
            b = state_in.b;
            c = state_in.c;
        end
        ks = '0;

        // The first keystream bit ends up in the most significant position.
        for (int i = 0; i < BYTE_W; i++) begin
            bit_ks = a[LEN_A-1] ^ b[LEN_B-1] ^ c[LEN_C-1];
            ks     = {ks[BYTE_W-2:0], bit_ks};
            ca     = a[10];
            cb     = b[11];
            cc     = c[12];
            maj    = (ca & cb) | (ca & cc) | (cb & cc);
            if (ca == maj) begin
                a = {a[LEN_A-2:0], a[0] ^ a[1] ^ a[2] ^ a[5]};
            end
            if (cb == maj) begin
                b = {b[LEN_B-2:0], b[0] ^ b[1]};
            end
            if (cc == maj) begin
                c = {c[LEN_C-2:0], c[0] ^ c[1] ^ c[2] ^ c[15]};
            end
        end

        state_out.a = a;
        state_out.b = b;
        state_out.c = c;
        data_out    = data_in ^ ks;
    end

endmodule

`default_nettype wire

// ----- rtl/mclsc_checker.sv -----
// Port-level checker for the cipher top level, attached by a bind statement.
`default_nettype none

`include "assert_macros.svh"

module mclsc_checker (
    input wire       aclk,
    input wire       aresetn,
    input wire       s_tvalid,
    input wire       s_tready,
    input wire       m_tvalid,
    input wire       m_tready,
    input wire [7:0] m_tdata
);

    // A stalled result stays offered and unchanged.
    `CHK_NEXT(a_out_hold, aclk, aresetn, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // Reset leaves no result on offer.
    `CHK_NEXT_ALWAYS(a_reset_empty, aclk, !aresetn, !m_tvalid)

    // With the output register empty, the input side can never be blocked.
    `CHK_IMPLIES(a_ready_when_empty, aclk, aresetn, !m_tvalid, s_tready)

    // A result appearing on an empty output comes from a transaction that passed the input register.
    `CHK_IMPLIES(a_rise_has_source, aclk, aresetn, $rose(m_tvalid),
                 $past(s_tvalid && s_tready, 2))

endmodule

bind majority_clocked_lfsr_stream_cipher_top mclsc_checker u_mclsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
